[rtl/hte_pkg.sv]
package hte_pkg;

  // angle and CORDIC sizing
  localparam int ANGLE_BITS    = 24;
  localparam int CORDIC_STAGES = 22;
  localparam int TW            = 32;              // internal turn angle
  localparam int CW            = 33;              // vector component, Q30
  localparam int PW            = 2 * CW;          // full product
  localparam int FRAC          = 30;
  localparam int ZW            = 34;              // residual angle in rotation mode
  localparam int SHIFT         = TW - ANGLE_BITS;

  localparam logic signed [CW-1:0] GAIN_Q  = CW'(652032874);
  localparam logic [TW-1:0]        HALF    = 32'h8000_0000;
  localparam logic [TW-1:0]        QUARTER = 32'h4000_0000;
  localparam logic signed [PW:0]   ROUND_Q = (PW + 1)'(1) <<< (FRAC - 1);
  localparam logic [TW:0]          TURN_RND =
    (SHIFT == 0) ? '0 : ((TW + 1)'(1) << ((SHIFT > 0) ? SHIFT - 1 : 0));

  // atan(2^-i) as a fraction of a turn
  localparam logic [TW-1:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [ANGLE_BITS-1:0]        azimuth;
    logic signed [ANGLE_BITS-1:0] altitude;
  } hte_in_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0]        hour_angle;
    logic signed [ANGLE_BITS-1:0] declination;
    logic                         at_pole;
  } hte_out_t;

  // round half up from Q60 back to Q30
  function automatic logic signed [CW-1:0] round_q(input logic signed [PW:0] p);
    logic signed [PW:0] t;
    t = p + ROUND_Q;
    return $signed(t[FRAC+CW-1:FRAC]);
  endfunction

  // 32-bit turn angle to output width, rounded and wrapped
  function automatic logic [ANGLE_BITS-1:0] from_turn(input logic [TW-1:0] t);
    logic [TW:0] s;
    s = {1'b0, t} + TURN_RND;
    return s[TW-1:SHIFT];
  endfunction

endpackage

[rtl/horizontal_to_equatorial.sv]
// Horizontal to equatorial conversion, fully pipelined.
// Input channel in_valid/in_stall/in_data carries azimuth and altitude;
// a transaction completes on a clock edge with valid high and stall low.
// Result channel out_valid/out_stall/out_data gives hour angle,
// declination and the pole flag, one result per input, in order.
// site_latitude is written over the APB-style cfg_ port at address 0 (any address with cfg_paddr[2] low).
// The user must write it only while the pipeline is empty; the block
// does not enforce this. Reads return the sign-extended value.
// The pipeline is three unrolled CORDIC chains (sine/cosine, then two
// vectoring passes) with the multiply and rounding stages between them.
// Throughput: one transaction per cycle while out_stall does not hold the pipeline.
// When out_valid is high and out_stall is high, the whole pipeline holds
// and in_stall is raised; nothing is dropped or repeated.
// Synchronous active-low reset clears all valid bits and sets latitude 0.
module horizontal_to_equatorial import hte_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  hte_in_t       in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output hte_out_t      out_data,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);

  localparam int N   = CORDIC_STAGES;
  localparam int SCL = N + 2;        // sine/cosine latency
  localparam int VL  = N + 1;        // vectoring latency

  logic en;
  logic signed [ANGLE_BITS-1:0] lat_r;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? 32'(lat_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == 1'b0)) begin
      lat_r <= cfg_pwdata[ANGLE_BITS-1:0];
    end
  end

  // global advance
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // angles as 32-bit turns
  logic [TW-1:0] alt_t, az_t, rot_t;
  assign alt_t = 32'($unsigned(in_data.altitude)) << SHIFT;
  assign az_t  = 32'(in_data.azimuth) << SHIFT;
  assign rot_t = QUARTER - (32'($unsigned(lat_r)) << SHIFT);

  logic signed [CW-1:0] ca, sa, cz, sz, cr, sr;

  hte_sincos u_sc_alt (.clk, .en, .angle(alt_t), .cos_q(ca), .sin_q(sa));
  hte_sincos u_sc_az  (.clk, .en, .angle(az_t),  .cos_q(cz), .sin_q(sz));
  hte_sincos u_sc_rot (.clk, .en, .angle(rot_t), .cos_q(cr), .sin_q(sr));

  logic [SCL-1:0] vsc_r;
  logic [3:0]     vm_r;

  // horizontal vector and rotation, four stages
  logic signed [PW-1:0] phx_r, phy_r, p1_r, p2_r, p3_r, p4_r;
  logic signed [CW-1:0] sa1_r, cr1_r, sr1_r;
  logic signed [CW-1:0] hx2_r, hy2_r, hz2_r, cr2_r, sr2_r, ey3_r;
  logic signed [CW-1:0] ex4_r, ey4_r, ez4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      phx_r <= ca * cz;
      phy_r <= ca * sz;
      sa1_r <= sa;
      cr1_r <= cr;
      sr1_r <= sr;
      hx2_r <= round_q((PW + 1)'(phx_r));
      hy2_r <= round_q((PW + 1)'(phy_r));
      hz2_r <= sa1_r;
      cr2_r <= cr1_r;
      sr2_r <= sr1_r;
      p1_r  <= cr2_r * hx2_r;
      p2_r  <= sr2_r * hz2_r;
      p3_r  <= sr2_r * hx2_r;
      p4_r  <= cr2_r * hz2_r;
      ey3_r <= hy2_r;
      ex4_r <= round_q((PW + 1)'(p1_r) - (PW + 1)'(p2_r));
      ez4_r <= round_q((PW + 1)'(p3_r) + (PW + 1)'(p4_r));
      ey4_r <= ey3_r;
    end
  end

  // first vectoring pass: hour angle and xy length
  logic signed [CW-1:0] mag1, mag2;
  logic [TW-1:0]        ang1, ang2;
  logic                 pole4;

  assign pole4 = (ex4_r == '0) && (ey4_r == '0);

  hte_vec u_vec_ha (.clk, .en, .x_in(ex4_r), .y_in(ey4_r), .mag(mag1), .ang(ang1));

  logic [VL-1:0]        vv1_r;
  logic signed [CW-1:0] ez_d_r [VL];
  logic                 pole_d_r [VL];

  always_ff @(posedge clk) begin
    if (en) begin
      ez_d_r[0]   <= ez4_r;
      pole_d_r[0] <= pole4;
      for (int i = 1; i < VL; i++) begin
        ez_d_r[i]   <= ez_d_r[i-1];
        pole_d_r[i] <= pole_d_r[i-1];
      end
    end
  end

  // length scaling, two stages
  logic signed [PW-1:0] prho_r;
  logic signed [CW-1:0] rho6_r, ez5_r, ez6_r;
  logic [TW-1:0]        tau5_r, tau6_r;
  logic                 pole5_r, pole6_r;
  logic [1:0]           vr_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prho_r  <= mag1 * GAIN_Q;
      tau5_r  <= pole_d_r[VL-1] ? HALF : ang1 + HALF;
      ez5_r   <= ez_d_r[VL-1];
      pole5_r <= pole_d_r[VL-1];
      rho6_r  <= round_q((PW + 1)'(prho_r));
      tau6_r  <= tau5_r;
      ez6_r   <= ez5_r;
      pole6_r <= pole5_r;
    end
  end

  // second vectoring pass: declination
  hte_vec u_vec_dec (.clk, .en, .x_in(rho6_r), .y_in(ez6_r), .mag(mag2), .ang(ang2));

  logic [VL-1:0] vv2_r;
  logic [TW-1:0] tau_d_r  [VL];
  logic          pol_d_r  [VL];
  logic          zero_d_r [VL];

  always_ff @(posedge clk) begin
    if (en) begin
      tau_d_r[0]  <= tau6_r;
      pol_d_r[0]  <= pole6_r;
      zero_d_r[0] <= (ez6_r == '0) && (rho6_r == '0);
      for (int i = 1; i < VL; i++) begin
        tau_d_r[i]  <= tau_d_r[i-1];
        pol_d_r[i]  <= pol_d_r[i-1];
        zero_d_r[i] <= zero_d_r[i-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.hour_angle  <= from_turn(tau_d_r[VL-1]);
      out_data.declination <= zero_d_r[VL-1] ? '0 : $signed(from_turn(ang2));
      out_data.at_pole     <= pol_d_r[VL-1];
    end
  end

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsc_r     <= '0;
      vm_r      <= '0;
      vv1_r     <= '0;
      vr_r      <= '0;
      vv2_r     <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vsc_r     <= {vsc_r[SCL-2:0], in_valid};
      vm_r      <= {vm_r[2:0], vsc_r[SCL-1]};
      vv1_r     <= {vv1_r[VL-2:0], vm_r[3]};
      vr_r      <= {vr_r[0], vv1_r[VL-1]};
      vv2_r     <= {vv2_r[VL-2:0], vr_r[1]};
      out_valid <= vv2_r[VL-1];
    end
  end

  // magnitude of the declination pass is not needed
  logic unused_mag;
  assign unused_mag = ^mag2;

endmodule

[rtl/hte_sincos.sv]
module hte_sincos import hte_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [TW-1:0]        angle,
  output logic signed [CW-1:0] cos_q,
  output logic signed [CW-1:0] sin_q
);

  localparam int N = CORDIC_STAGES;

  logic signed [CW-1:0] x_r [N+1];
  logic signed [CW-1:0] y_r [N+1];
  logic signed [ZW-1:0] z_r [N+1];
  logic                 flip_r [N+1];

  // fold into the right half plane; flip result sign when folded
  always_ff @(posedge clk) begin
    if (en) begin
      flip_r[0] <= angle[31] ^ angle[30];
      x_r[0]    <= GAIN_Q;
      y_r[0]    <= '0;
      z_r[0]    <= ZW'($signed({angle[30], angle[30:0]}));
    end
  end

  // one micro-rotation per stage
  for (genvar k = 0; k < N; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[k+1] <= flip_r[k];
        if (!z_r[k][ZW-1]) begin
          x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] - $signed({2'b00, ATAN_TURNS[k]});
        end else begin
          x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] + $signed({2'b00, ATAN_TURNS[k]});
        end
      end
    end
  end

  // undo fold
  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= flip_r[N] ? -x_r[N] : x_r[N];
      sin_q <= flip_r[N] ? -y_r[N] : y_r[N];
    end
  end

endmodule

[rtl/hte_vec.sv]
module hte_vec import hte_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  output logic signed [CW-1:0] mag,
  output logic [TW-1:0]        ang
);

  localparam int N = CORDIC_STAGES;

  logic signed [CW-1:0] x_r [N+1];
  logic signed [CW-1:0] y_r [N+1];
  logic [TW-1:0]        z_r [N+1];

  // left half plane: mirror through origin, start at half a turn
  always_ff @(posedge clk) begin
    if (en) begin
      if (x_in[CW-1]) begin
        x_r[0] <= -x_in;
        y_r[0] <= -y_in;
        z_r[0] <= HALF;
      end else begin
        x_r[0] <= x_in;
        y_r[0] <= y_in;
        z_r[0] <= '0;
      end
    end
  end

  // drive y towards zero, angle accumulates
  for (genvar k = 0; k < N; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[k][CW-1]) begin
          x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] + ATAN_TURNS[k];
        end else begin
          x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] - ATAN_TURNS[k];
        end
      end
    end
  end

  assign mag = x_r[N];
  assign ang = z_r[N];

endmodule

[tb/sv/horizontal_to_equatorial_tb.sv]
`timescale 1ns / 100ps

// Expected-result store and coordinate predictor
class hte_scoreboard;
  logic [23:0] latitude;
  hte_pkg::hte_out_t pending_q[$];
  int errors;
  int checked;

  function new();
    latitude = '0;
    errors   = 0;
    checked  = 0;
  endfunction

  function longint mul_q30(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // cos/sin of a 32-bit turn angle, Q30
  function void rotate_unit(input logic [31:0] a, output longint c, output longint s);
    logic [31:0] t;
    bit flip;
    longint x, y, z, dx, dy;
    t = a + 32'h4000_0000;
    flip = t[31];
    if (flip) a = a - 32'h8000_0000;
    z = longint'($signed(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < hte_pkg::CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(hte_pkg::ATAN_TURNS[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(hte_pkg::ATAN_TURNS[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // atan2(y, x) as a turn angle, scaled magnitude out
  function logic [31:0] vector_angle(input longint x, input longint y, output longint mag);
    logic [31:0] z;
    longint dx, dy;
    z = '0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h8000_0000;
    end
    for (int i = 0; i < hte_pkg::CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + hte_pkg::ATAN_TURNS[i];
      end else begin
        x = x - dx; y = y + dy; z = z - hte_pkg::ATAN_TURNS[i];
      end
    end
    mag = mul_q30(x, 652032874);
    return z;
  endfunction

  function logic [23:0] to_out_angle(input logic [31:0] t);
    logic [32:0] s;
    s = {1'b0, t} + 33'd128;
    return s[31:8];
  endfunction

  function hte_pkg::hte_out_t convert(input hte_pkg::hte_in_t d);
    hte_pkg::hte_out_t r;
    longint ca, sa, cz, sz, cr, sr, hx, hy, hz, ex, ey, ez, rho, unused;
    logic [31:0] tau, de;
    bit pole;
    rotate_unit({d.altitude, 8'h00}, ca, sa);
    rotate_unit({d.azimuth, 8'h00}, cz, sz);
    hx = mul_q30(ca, cz);
    hy = mul_q30(ca, sz);
    hz = sa;
    rotate_unit(32'h4000_0000 - {latitude, 8'h00}, cr, sr);
    ex = (cr * hx - sr * hz + (64'sd1 <<< 29)) >>> 30;
    ey = hy;
    ez = (sr * hx + cr * hz + (64'sd1 <<< 29)) >>> 30;
    rho = 0;
    de = '0;
    pole = (ex == 0 && ey == 0);
    if (pole) tau = 32'h8000_0000;
    else tau = vector_angle(ex, ey, rho) + 32'h8000_0000;
    if (!(ez == 0 && rho == 0)) de = vector_angle(rho, ez, unused);
    r.hour_angle  = to_out_angle(tau);
    r.declination = to_out_angle(de);
    r.at_pole     = pole;
    return r;
  endfunction

  function void note_input(input hte_pkg::hte_in_t d);
    pending_q.push_back(convert(d));
  endfunction

  function void check_result(input hte_pkg::hte_out_t got);
    hte_pkg::hte_out_t exp_r;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result %h", $realtime, got);
      errors++;
      return;
    end
    exp_r = pending_q.pop_front();
    checked++;
    if (got.hour_angle !== exp_r.hour_angle) begin
      $display("%0t: hour_angle exp %h got %h", $realtime, exp_r.hour_angle, got.hour_angle);
      errors++;
    end
    if (got.declination !== exp_r.declination) begin
      $display("%0t: declination exp %h got %h", $realtime, exp_r.declination,
               got.declination);
      errors++;
    end
    if (got.at_pole !== exp_r.at_pole) begin
      $display("%0t: at_pole exp %b got %b", $realtime, exp_r.at_pole, got.at_pole);
      errors++;
    end
  endfunction
endclass

module horizontal_to_equatorial_tb;
  import hte_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int ITEMS_PER_PHASE = 225;
  localparam logic [2:0] ADDR_LATITUDE = 3'd0;
  localparam logic [2:0] ADDR_UNUSED   = 3'd4;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  hte_in_t in_data;
  hte_out_t out_data;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  hte_scoreboard sb = new();
  int gap_pct, stall_pct, idle_count;
  int poles_seen;

  horizontal_to_equatorial dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stall and result checking
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (out_data.at_pole) poles_seen++;
      sb.check_result(out_data);
    end
  end

  // watchdog on transaction activity
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", idle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(input hte_in_t d);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall);
    sb.note_input(d);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [23:0] value);
    in_valid    <= 1'b0;
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= {{8{value[23]}}, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_LATITUDE) sb.latitude = value;
  endtask

  // hold off until every transaction has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic hte_in_t random_item();
    hte_in_t d;
    d.azimuth = 24'($urandom());
    if ($urandom_range(9) == 0) d.altitude = 24'($urandom());
    else d.altitude = 24'($signed($urandom_range(8388608)) - 4194304);
    return d;
  endfunction

  initial begin
    logic [23:0] lat_plan [6];
    logic [23:0] az_dir [6];
    logic [23:0] alt_dir [4];
    lat_plan = '{24'h000000, 24'h400000, 24'hC00000, 24'h1C71C7, 24'hE38E39, 24'h7FFFFF};
    az_dir   = '{24'h000000, 24'hFFFFFF, 24'h400000, 24'h800000, 24'hC00000, 24'h155555};
    alt_dir  = '{24'h000000, 24'h400000, 24'hC00000, 24'h7FFFFF};
    rst_n = 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    gap_pct = 0;
    stall_pct = 0;
    poles_seen = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin gap_pct = 21; stall_pct = 67; end
        1: begin gap_pct = 67; stall_pct = 21; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      if (p != 0) write_reg(ADDR_LATITUDE, lat_plan[p]);
      if (p == 3) write_reg(ADDR_UNUSED, 24'h123456);
      // extremes of both angles; pole and zenith cases included
      if (p < 3) begin
        foreach (alt_dir[j]) begin
          send_item('{azimuth: az_dir[j], altitude: alt_dir[j]});
          send_item('{azimuth: az_dir[j + 2], altitude: alt_dir[j]});
        end
        send_item('{azimuth: 24'h800000, altitude: 24'h800000});
        send_item('{azimuth: 24'h000001, altitude: 24'hFFFFFF});
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_item(random_item());
        // occasional mid-phase pause until all results are back
        if ($urandom_range(99) == 0) drain();
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d conversions over six site latitudes, %0d at the pole,",
             sb.checked, poles_seen);
    $display("with sender gaps and receiver stalls in both mixes and none.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
